/* src/frame_rate_meter_limiter_core_assert.svh */
// Assertion macros for the frame rate meter and limiter.
// Used by the top level; no other dependencies.
`ifndef FRAME_RATE_METER_LIMITER_CORE_ASSERT_SVH
`define FRAME_RATE_METER_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FRLM_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("frlm: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define FRLM_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("frlm: next-cycle check failed");

`endif

/* src/frlm_pkg.sv */
// Shared types, constants and the microcode table of the frame rate meter.
// No dependencies.
package frlm_pkg;

    localparam int SAMPLES_DEF    = 10;
    localparam int TS_W           = 32;
    localparam int FPS_W          = 22;
    localparam int PERIOD_W       = 16;
    localparam int DELAY_W        = 10;
    localparam int CAP_W          = 10;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int MS_PER_S       = 1000;
    localparam int FPS_SCALE      = 256000;       // 1000 ms/s in Q.8
    localparam int FPS_DEFAULT_Q8 = 60 * 256;
    localparam int MAX_FPS_RESET  = 60;

    // register index (paddr[2])
    localparam logic REG_MAX_FPS = 1'b0;

    function automatic int num_width(input int samples);
        return $clog2(FPS_SCALE * samples + 1);
    endfunction

    function automatic int sum_width(input int samples);
        return $clog2(65535 * samples + 1);
    endfunction

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        U_ACCEPT,
        U_RING,
        U_LOAD_FPS,
        U_DIV_STEP,
        U_STORE_FPS,
        U_LOAD_CAP,
        U_EMIT,
        U_NOP
    } uop_t;

    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_NO_ITEM,
        J_DIV_BUSY,
        J_OUT_BUSY
    } jmp_t;

    typedef struct packed {
        uop_t  op;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    localparam step_t ST_ACCEPT  = 4'd0;
    localparam step_t ST_RING    = 4'd1;
    localparam step_t ST_LOAD_F  = 4'd2;
    localparam step_t ST_DIV_F   = 4'd3;
    localparam step_t ST_STORE_F = 4'd4;
    localparam step_t ST_LOAD_C  = 4'd5;
    localparam step_t ST_DIV_C   = 4'd6;
    localparam step_t ST_EMIT    = 4'd7;
    localparam step_t ST_BACK    = 4'd8;

    // Control store: jump to target when the condition holds, else fall through.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            ST_ACCEPT:  w = '{op: U_ACCEPT,    jmp: J_NO_ITEM,  target: ST_ACCEPT};
            ST_RING:    w = '{op: U_RING,      jmp: J_NONE,     target: ST_ACCEPT};
            ST_LOAD_F:  w = '{op: U_LOAD_FPS,  jmp: J_NONE,     target: ST_ACCEPT};
            ST_DIV_F:   w = '{op: U_DIV_STEP,  jmp: J_DIV_BUSY, target: ST_DIV_F};
            ST_STORE_F: w = '{op: U_STORE_FPS, jmp: J_NONE,     target: ST_ACCEPT};
            ST_LOAD_C:  w = '{op: U_LOAD_CAP,  jmp: J_NONE,     target: ST_ACCEPT};
            ST_DIV_C:   w = '{op: U_DIV_STEP,  jmp: J_DIV_BUSY, target: ST_DIV_C};
            ST_EMIT:    w = '{op: U_EMIT,      jmp: J_OUT_BUSY, target: ST_EMIT};
            ST_BACK:    w = '{op: U_NOP,       jmp: J_ALWAYS,   target: ST_ACCEPT};
            default:    w = '{op: U_NOP,       jmp: J_ALWAYS,   target: ST_ACCEPT};
        endcase
        return w;
    endfunction

    typedef struct packed {
        logic load;
        logic step;
        logic short_run;   // run CAP_W steps instead of the full width
    } div_ctrl_t;

endpackage

/* src/frlm_if.sv */
// Valid/ready channel interfaces for frame items and meter results.
// Depends on frlm_pkg.
interface frlm_in_if import frlm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] frame_start_ms;
    logic [TS_W-1:0] frame_end_ms;

    modport source (output valid, frame_start_ms, frame_end_ms, input ready);
    modport sink   (input valid, frame_start_ms, frame_end_ms, output ready);
endinterface

interface frlm_out_if import frlm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FPS_W-1:0]    fps_q8;
    logic [PERIOD_W-1:0] period_ms;
    logic [DELAY_W-1:0]  delay_ms;

    modport source (output valid, fps_q8, period_ms, delay_ms, input ready);
    modport sink   (input valid, fps_q8, period_ms, delay_ms, output ready);
endinterface

/* src/frlm_div.sv */
// Restoring divider, one quotient bit per step, shared by both divisions.
// Depends on frlm_pkg.
module frlm_div import frlm_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF,
    localparam int NUM_W = num_width(SAMPLES),
    localparam int SUM_W = sum_width(SAMPLES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] numer,
    input  logic [SUM_W-1:0] denom,
    output logic [NUM_W-1:0] quot,
    output logic             last
);

    localparam int BITS_W = $clog2(NUM_W + 1);

    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [SUM_W:0]    rem_shift;
    logic [SUM_W:0]    diff;
    logic              q_bit;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        q_bit     = ~diff[SUM_W];
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        if (ctrl.load)
        begin
            rem_next  = '0;
            num_next  = numer;
            den_next  = denom;
            bits_next = ctrl.short_run ? BITS_W'(CAP_W) : BITS_W'(NUM_W);
        end
        else if (ctrl.step)
        begin
            rem_next  = q_bit ? diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            num_next  = {num_reg[NUM_W-2:0], q_bit};
            bits_next = bits_reg - BITS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign quot = num_reg;
    assign last = (bits_reg == BITS_W'(1));

endmodule

/* src/frame_rate_meter_limiter_core.sv */
// Frame rate meter and limiter: microcoded sequencer, ring of periods, APB register.
// Depends on frlm_pkg, frlm_if, frlm_div and frame_rate_meter_limiter_core_assert.svh.
//
//  channel    dir  handshake             payload
//  frame_ch   in   valid/ready           frame_start_ms, frame_end_ms
//  result_ch  out  valid/ready           fps_q8, period_ms, delay_ms
//  apb        in   psel/penable, pready  paddr, pwdata -> prdata (max_fps at 0x0)
//
// One item at a time: no new item is accepted before the current one is emitted. The
// one-bit-per-step divider runs 256000*count/sum and then 1000/cap (cap = max_fps, min 1).
// The result register frees the sequencer: it stalls at the emit step only while
// an earlier result is still untaken. Reset is immediate, no clearing pass;
// ring read data is only used once its entry has been written.
`include "frame_rate_meter_limiter_core_assert.svh"

module frame_rate_meter_limiter_core import frlm_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    frlm_in_if.sink               frame_ch,
    frlm_out_if.source            result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NUM_W  = num_width(SAMPLES);
    localparam int SUM_W  = sum_width(SAMPLES);
    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int PROD_W = 2 * CAP_W;

    // configuration
    logic [CAP_W-1:0] max_fps_reg, max_fps_next;
    logic [CAP_W-1:0] cap;
    logic             cfg_wr;

    // sequencer
    step_t  step_reg, step_next;
    uword_t uw;
    logic   jump;

    // state
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  filled_count_reg, filled_count_next;
    logic [TS_W-1:0]   last_end_reg, last_end_next;
    logic              seen_first_reg, seen_first_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              full;

    // working payload
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [CAP_W-1:0]    dur_lo_reg, dur_lo_next;
    logic                dur_hi_zero_reg, dur_hi_zero_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [FPS_W-1:0]    fps_val_reg, fps_val_next;
    logic [TS_W-1:0]     end_diff;
    logic [TS_W-1:0]     dur;

    // ring
    logic [PERIOD_W-1:0] ring_mem [SAMPLES];
    logic [PERIOD_W-1:0] rd_data_reg;
    logic                ring_we;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [FPS_W-1:0]    out_fps_reg, out_fps_next;
    logic [PERIOD_W-1:0] out_period_reg, out_period_next;
    logic [DELAY_W-1:0]  out_delay_reg, out_delay_next;
    logic                out_busy;

    // divider
    div_ctrl_t        div_ctrl;
    logic [NUM_W-1:0] div_numer;
    logic [SUM_W-1:0] div_denom;
    logic [NUM_W-1:0] div_quot;
    logic             div_last;

    logic item_acc;

    // ---------------- APB register ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cap    = (max_fps_reg == '0) ? CAP_W'(1) : max_fps_reg;

    always_comb
    begin
        max_fps_next = max_fps_reg;
        if (cfg_wr && (paddr[2] == REG_MAX_FPS))
        begin
            max_fps_next = pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_FPS: prdata = APB_DATA_W'(max_fps_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign uw             = ucode(step_reg);
    assign frame_ch.ready = (uw.op == U_ACCEPT);
    assign item_acc       = frame_ch.valid && frame_ch.ready;
    assign out_busy       = out_valid_reg && !result_ch.ready;

    always_comb
    begin
        case (uw.jmp)
            J_NONE:     jump = 1'b0;
            J_ALWAYS:   jump = 1'b1;
            J_NO_ITEM:  jump = !frame_ch.valid;
            J_DIV_BUSY: jump = !div_last;
            J_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b1;
        endcase
        step_next = jump ? uw.target : step_reg + step_t'(1);
    end

    // ---------------- datapath ----------------
    assign full     = (filled_count_reg == CNT_W'(SAMPLES));
    assign end_diff = frame_ch.frame_end_ms - last_end_reg;
    assign dur      = frame_ch.frame_end_ms - frame_ch.frame_start_ms;
    assign ring_we  = (uw.op == U_RING);

    always_comb
    begin
        write_slot_next   = write_slot_reg;
        filled_count_next = filled_count_reg;
        last_end_next     = last_end_reg;
        seen_first_next   = seen_first_reg;
        sum_next          = sum_reg;
        period_next       = period_reg;
        dur_lo_next       = dur_lo_reg;
        dur_hi_zero_next  = dur_hi_zero_reg;
        prod_next         = prod_reg;
        fps_val_next      = fps_val_reg;
        out_valid_next    = out_valid_reg && !result_ch.ready;
        out_fps_next      = out_fps_reg;
        out_period_next   = out_period_reg;
        out_delay_next    = out_delay_reg;

        case (uw.op)
            U_ACCEPT:
            begin
                if (item_acc)
                begin
                    if (!seen_first_reg)
                        period_next = '0;
                    else if (end_diff[TS_W-1:PERIOD_W] != '0)
                        period_next = '1;
                    else
                        period_next = end_diff[PERIOD_W-1:0];
                    seen_first_next  = 1'b1;
                    last_end_next    = frame_ch.frame_end_ms;
                    dur_lo_next      = dur[CAP_W-1:0];
                    dur_hi_zero_next = (dur[TS_W-1:CAP_W] == '0);
                end
            end
            U_RING:
            begin
                // running sum: drop the period being overwritten once the ring is full
                sum_next = sum_reg - (full ? SUM_W'(rd_data_reg) : '0)
                           + SUM_W'(period_reg);
                write_slot_next = (write_slot_reg == SLOT_W'(SAMPLES - 1))
                                  ? '0 : write_slot_reg + SLOT_W'(1);
                if (!full)
                    filled_count_next = filled_count_reg + CNT_W'(1);
                prod_next = PROD_W'(dur_lo_reg) * PROD_W'(cap);
            end
            U_STORE_FPS:
            begin
                fps_val_next = (sum_reg == '0) ? FPS_W'(FPS_DEFAULT_Q8) : FPS_W'(div_quot);
            end
            U_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_fps_next    = fps_val_reg;
                    out_period_next = period_reg;
                    // quotient holds 1000/cap in its low bits here
                    if (dur_hi_zero_reg && (prod_reg < PROD_W'(MS_PER_S)))
                        out_delay_next = DELAY_W'(div_quot[CAP_W-1:0] - dur_lo_reg);
                    else
                        out_delay_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // divider hookup
    always_comb
    begin
        div_ctrl.load      = (uw.op == U_LOAD_FPS) || (uw.op == U_LOAD_CAP);
        div_ctrl.step      = (uw.op == U_DIV_STEP);
        div_ctrl.short_run = (uw.op == U_LOAD_CAP);
        if (uw.op == U_LOAD_CAP)
        begin
            // dividend sits in the top bits so CAP_W steps suffice
            div_numer = NUM_W'(MS_PER_S) << (NUM_W - CAP_W);
            div_denom = SUM_W'(cap);
        end
        else
        begin
            div_numer = NUM_W'(FPS_SCALE) * NUM_W'(filled_count_reg);
            div_denom = sum_reg;
        end
    end

    frlm_div #(
        .SAMPLES (SAMPLES)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .numer (div_numer),
        .denom (div_denom),
        .quot  (div_quot),
        .last  (div_last)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fps_reg      <= CAP_W'(MAX_FPS_RESET);
            step_reg         <= ST_ACCEPT;
            write_slot_reg   <= '0;
            filled_count_reg <= '0;
            last_end_reg     <= '0;
            seen_first_reg   <= 1'b0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            max_fps_reg      <= max_fps_next;
            step_reg         <= step_next;
            write_slot_reg   <= write_slot_next;
            filled_count_reg <= filled_count_next;
            last_end_reg     <= last_end_next;
            seen_first_reg   <= seen_first_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg      <= period_next;
        dur_lo_reg      <= dur_lo_next;
        dur_hi_zero_reg <= dur_hi_zero_next;
        prod_reg        <= prod_next;
        fps_val_reg     <= fps_val_next;
        out_fps_reg     <= out_fps_next;
        out_period_reg  <= out_period_next;
        out_delay_reg   <= out_delay_next;
    end

    // period ring, read data registered
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[write_slot_reg] <= period_reg;
        rd_data_reg <= ring_mem[write_slot_reg];
    end

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.fps_q8    = out_fps_reg;
    assign result_ch.period_ms = out_period_reg;
    assign result_ch.delay_ms  = out_delay_reg;

    // ---------------- checks ----------------
    `FRLM_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, filled_count_reg <= CNT_W'(SAMPLES))
    `FRLM_ASSERT_IMP(a_slot_tracks_fill, clk, rst_n, !full, CNT_W'(write_slot_reg) == filled_count_reg)
    `FRLM_ASSERT_IMP(a_empty_sum, clk, rst_n, filled_count_reg == '0, sum_reg == '0)
    `FRLM_ASSERT_NEXT(a_one_item, clk, rst_n, item_acc, !frame_ch.ready)

endmodule
